>>> hw/rtl/signed_int_to_decimal_ascii_assert.svh
// Assertion macros used by the RTL file of the decimal text converter.
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define SIDA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SIDA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hw/rtl/sida_pkg.sv
`default_nettype none

package sida_pkg;

    localparam int DEFAULT_VALUE_WIDTH = 32;

    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CONV,
        S_FIND,
        S_SIGN,
        S_DIGIT
    } t_state;

endpackage

`default_nettype wire

>>> hw/rtl/signed_int_to_decimal_ascii.sv
// Channel  | Ports                                  | Beat carries
// ---------+----------------------------------------+------------------------------------
// input    | i_s_tvalid, o_s_tready, i_s_tdata      | number (low VALUE_WIDTH bits)
// output   | o_m_tvalid, i_m_tready, o_m_tdata, ... | character in tdata, last char tlast
//
// One number is accepted, converted by double dabble two bits at a time (two chained
// shift/add-3 passes per step), scanned for its leading digit, and then sent one
// character at a time (up to 11 at 32 bits).
// o_s_tready is high only while no number is in conversion; the last character may still
// sit in the output register when the next number is taken.
// A stalled output holds the character register and holds the sequencer in the sign or digit state.
// Reset (synchronous, active low) clears the state and the output valid.
`default_nettype none

`include "signed_int_to_decimal_ascii_assert.svh"

module signed_int_to_decimal_ascii
    import sida_pkg::*;
#(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_s_tvalid,
    output logic                                o_s_tready,
    // [VALUE_WIDTH-1:0] number, zero filled up to whole bytes
    input  wire  [((VALUE_WIDTH + 7) / 8) * 8 - 1:0] i_s_tdata,
    output logic                                o_m_tvalid,
    input  wire                                 i_m_tready,
    // [7:0] character
    output logic [7:0]                          o_m_tdata,
    output logic                                o_m_tlast
);

    localparam int SHIFT_W = ((VALUE_WIDTH + 1) / 2) * 2;
    localparam int STEPS   = SHIFT_W / 2;
    localparam int STEP_W  = $clog2(STEPS);
    localparam int NDIG    = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_W   = NDIG * 4;
    localparam int IDX_W   = $clog2(NDIG);

    t_state                r_state, n_state;
    logic [SHIFT_W-1:0]    r_bin,   n_bin;
    logic [BCD_W-1:0]      r_bcd,   n_bcd;
    logic [STEP_W-1:0]     r_step,  n_step;
    logic [IDX_W-1:0]      r_idx,   n_idx;
    logic                  r_neg,   n_neg;
    logic                  r_m_valid, n_m_valid;
    logic [7:0]            r_char,  n_char;
    logic                  r_last,  n_last;

    logic [VALUE_WIDTH-1:0] w_val;
    logic [VALUE_WIDTH-1:0] w_mag;
    logic                   w_slot_free;
    logic [3:0]             w_digit;

    // One double-dabble step: adjust each BCD digit, then shift in one binary bit.
    function automatic logic [BCD_W-1:0] f_dabble(input logic [BCD_W-1:0] bcd,
                                                   input logic bin_bit);
        logic [BCD_W-1:0] adj;
        adj = bcd;
        for (int d = 0; d < NDIG; d++) begin
            if (bcd[d*4 +: 4] >= 4'd5) begin
                adj[d*4 +: 4] = bcd[d*4 +: 4] + 4'd3;
            end
        end
        return {adj[BCD_W-2:0], bin_bit};
    endfunction

    assign w_val       = i_s_tdata[VALUE_WIDTH-1:0];
    assign w_mag       = w_val[VALUE_WIDTH-1] ? (~w_val + 1'b1) : w_val;
    assign w_slot_free = !r_m_valid || i_m_tready;
    assign w_digit     = r_bcd[r_idx*4 +: 4];

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_char;
    assign o_m_tlast  = r_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bin  <= n_bin;
        r_bcd  <= n_bcd;
        r_step <= n_step;
        r_idx  <= n_idx;
        r_neg  <= n_neg;
        r_char <= n_char;
        r_last <= n_last;
    end

    always_comb begin
        n_state   = r_state;
        n_bin     = r_bin;
        n_bcd     = r_bcd;
        n_step    = r_step;
        n_idx     = r_idx;
        n_neg     = r_neg;
        n_char    = r_char;
        n_last    = r_last;
        n_m_valid = r_m_valid;

        // drop the output beat once taken
        if (i_m_tready) begin
            n_m_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_neg   = w_val[VALUE_WIDTH-1];
                    n_bin   = SHIFT_W'(w_mag);
                    n_bcd   = '0;
                    n_step  = STEP_W'(STEPS - 1);
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                n_bcd = f_dabble(f_dabble(r_bcd, r_bin[SHIFT_W-1]), r_bin[SHIFT_W-2]);
                n_bin = {r_bin[SHIFT_W-3:0], 2'b00};
                if (r_step == '0) begin
                    n_state = S_FIND;
                end else begin
                    n_step = r_step - 1'b1;
                end
            end
            S_FIND: begin
                // highest nonzero digit; zero leaves the units digit
                n_idx = '0;
                for (int d = 0; d < NDIG; d++) begin
                    if (r_bcd[d*4 +: 4] != 4'd0) begin
                        n_idx = IDX_W'(d);
                    end
                end
                n_state = r_neg ? S_SIGN : S_DIGIT;
            end
            S_SIGN: begin
                if (w_slot_free) begin
                    n_char    = CHAR_MINUS;
                    n_last    = 1'b0;
                    n_m_valid = 1'b1;
                    n_state   = S_DIGIT;
                end
            end
            S_DIGIT: begin
                if (w_slot_free) begin
                    n_char    = CHAR_ZERO + {4'b0000, w_digit};
                    n_last    = (r_idx == '0);
                    n_m_valid = 1'b1;
                    if (r_idx == '0) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    `SIDA_ASSERT_NEXT(a_accept_starts_conv, i_s_tvalid && o_s_tready, r_state == S_CONV, "accepted number did not start conversion")
    `SIDA_ASSERT_NOW(a_beat_from_emit, $rose(o_m_tvalid), $past(r_state) == S_SIGN || $past(r_state) == S_DIGIT, "output beat loaded outside emit states")
    `SIDA_ASSERT_NOW(a_minus_not_last, o_m_tvalid && o_m_tdata == CHAR_MINUS, !o_m_tlast, "minus sign marked as last character")
    `SIDA_ASSERT_NOW(a_digit_is_bcd, r_state == S_DIGIT, w_digit <= 4'd9, "converted digit out of decimal range")

endmodule

`default_nettype wire

>>> tb/tb.sv
module tb;
    import sida_pkg::*;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_text_beat;

    // An empty text means the row is checked against the predictor.
    typedef struct {
        logic [31:0] number;
        string       text;
    } t_stim_row;

    localparam int RANDOM_ITEMS = 194;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 40;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        m_tlast;

    t_text_beat  expected_chars[$];
    int unsigned mismatches = 0;
    bit          quiet = 1'b0;
    bit          long_hold = 1'b0;

    t_stim_row directed_rows [20] = '{
        '{32'h0000_0000, "0"},
        '{32'hFFFF_FFFF, "-1"},
        '{32'h7FFF_FFFF, "2147483647"},
        '{32'h8000_0000, "-2147483648"},
        '{32'h8000_0001, "-2147483647"},
        '{32'd1,         ""},
        '{32'd9,         ""},
        '{32'd10,        ""},
        '{-32'sd10,      ""},
        '{32'd99,        ""},
        '{32'd100,       ""},
        '{-32'sd5,       ""},
        '{32'd999999999, ""},
        '{32'd1000000000, ""},
        '{-32'sd1000000000, ""},
        '{32'd123456789, ""},
        '{-32'sd987654321, ""},
        '{32'h5555_5555, ""},
        '{32'hAAAA_AAAA, ""},
        '{32'h7FFF_FFFE, ""}
    };

    signed_int_to_decimal_ascii dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),
        .o_m_tlast  (m_tlast)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("FAILURE");
        $finish;
    end

    // Widen by one bit before negating so the most negative value stays exact.
    function automatic void predict_text(input logic [31:0] number);
        logic [32:0] mag;
        logic [7:0]  digits[$];
        int          k;
        mag = number[31] ? (33'd0 - {number[31], number}) : {1'b0, number};
        do begin
            digits.push_front(CHAR_ZERO + 8'(mag % 33'd10));
            mag = mag / 33'd10;
        end while (mag != 33'd0);
        if (number[31])
            expected_chars.push_back('{CHAR_MINUS, 1'b0});
        for (k = 0; k < digits.size(); k++)
            expected_chars.push_back('{digits[k], k == digits.size() - 1});
    endfunction

    function automatic void push_text(input string text);
        int k;
        for (k = 0; k < text.len(); k++)
            expected_chars.push_back('{8'(text[k]), k == text.len() - 1});
    endfunction

    function automatic logic [31:0] random_number();
        logic [63:0] span;
        logic [31:0] v;
        int          d;
        case ($urandom_range(0, 9))
            0, 1, 2: v = $urandom;
            3, 4, 5: begin
                d = $urandom_range(1, 10);
                span = 64'd1;
                repeat (d) span = span * 64'd10;
                if (d == 10)
                    span = 64'h8000_0000;
                v = 32'({$urandom, $urandom} % span);
                if ($urandom_range(0, 1))
                    v = -v;
            end
            6: v = $urandom_range(0, 1) ? 32'h8000_0000 + $urandom_range(0, 3)
                                        : 32'h7FFF_FFFF - $urandom_range(0, 3);
            7: begin
                v = 32'd1;
                repeat ($urandom_range(0, 9)) v = v * 32'd10;
                v = v + $urandom_range(0, 2) - 32'd1;
                if ($urandom_range(0, 1))
                    v = -v;
            end
            8: v = 32'($urandom_range(0, 19)) - 32'd10;
            default: v = $urandom & $urandom & $urandom;
        endcase
        return v;
    endfunction

    // Offer one number after an optional idle gap; expectations are queued on the accepting edge.
    task automatic offer(input logic [31:0] number, input string text);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= number;
        @(posedge i_clk);
        while (!s_tready) @(posedge i_clk);
        if (text.len() > 0)
            push_text(text);
        else
            predict_text(number);
    endtask

    initial begin
        int n;
        i_rst_n  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_rows[r])
            offer(directed_rows[r].number, directed_rows[r].text);

        // Stall the output for a long stretch while numbers keep coming back to back.
        quiet = 1'b1;
        long_hold = 1'b1;
        repeat (6) offer(random_number(), "");
        quiet = 1'b0;

        for (n = 0; n < RANDOM_ITEMS; n++) begin
            quiet = (n % 50) >= 35;
            if (n == RANDOM_ITEMS / 2) begin
                // Drain completely before going on.
                s_tvalid <= 1'b0;
                wait (expected_chars.size() == 0);
                @(posedge i_clk);
            end
            offer(random_number(), "");
        end
        quiet = 1'b0;
        s_tvalid <= 1'b0;

        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0 && expected_chars.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        int         stall;
        t_text_beat want;
        m_tready <= 1'b0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            stall = quiet ? 0 : $urandom_range(0, 14);
            if (long_hold) begin
                stall = LONG_HOLD_CYCLES;
                long_hold = 1'b0;
            end
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            m_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_tvalid) @(posedge i_clk);
            if (expected_chars.size() == 0) begin
                $display("%0t: unexpected beat, actual char %h last %b",
                         $time, m_tdata, m_tlast);
                mismatches++;
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata !== want.ch) begin
                    $display("%0t: char mismatch, expected %h actual %h",
                             $time, want.ch, m_tdata);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $display("%0t: last mismatch, expected %b actual %b",
                             $time, want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

endmodule
